>>> rtl/core/owbm_pkg.sv
package owbm_pkg;

    // Longest transfer in bits; larger counts are clamped to this
    localparam int MAX_BITS = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Timing register indexes on the write port
    typedef enum logic [2:0] {
        REG_RECOVERY      = 3'd0,
        REG_RESET_LOW     = 3'd1,
        REG_PRESENCE_IVL  = 3'd2,
        REG_WRITE_SLOT    = 3'd3,
        REG_WRITE_START   = 3'd4,
        REG_READ_START    = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_SLOT     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  bit_count;
        logic [15:0] write_data;
        logic        line_in;
    } tick_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic [9:0]  presence_count;
    } res_t;

    typedef struct packed {
        logic [9:0] recovery_us;
        logic [9:0] reset_low_us;
        logic [7:0] presence_interval_us;
        logic [7:0] write_slot_us;
        logic [7:0] write_start_us;
        logic [7:0] read_start_us;
        logic [7:0] read_sample_offset_us;
        logic [7:0] read_slot_us;
    } cfg_t;

    // Classified item as held in the queue
    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  count;
        logic [15:0] wdata;
        logic        line;
    } job_t;

endpackage

>>> rtl/core/one_wire_bus_master.sv
// Channel  Dir  Handshake                 Payload
// tick     in   tick_valid / tick_ready   tick_data (command, bit_count, write_data, line_in)
// res      out  res_valid  / res_ready    res_data (drive_low, busy_res, done_res,
//                                                   read_data, presence_count)
// cfg      in   cfg_write                 cfg_index (register), cfg_data
//
// One item per cycle while a phase runs and the result register is free; a tick that starts
// a command walks into its first phase and runs one tick of it in ST_BODY, or emits from the
// walk when the command ends on that same tick; each zero-length phase adds an ST_PRE or ST_POST step.
// Reset leaves the bus idle with all timing registers at their defaults; no clearing pass.
// Items queue in front of the sequencer; a full result register stalls the sequencer,
// and a full queue drops tick_ready.
module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  tick_t      tick_data,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res_data,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data
);

    localparam cfg_t CFG_RESET = '{
        recovery_us:           10'd200,
        reset_low_us:          10'd480,
        presence_interval_us:  8'd15,
        write_slot_us:         8'd60,
        write_start_us:        8'd1,
        read_start_us:         8'd1,
        read_sample_offset_us: 8'd10,
        read_slot_us:          8'd15
    };

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic job_valid;
    job_t job;
    logic job_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RECOVERY:     cfg_next.recovery_us           = cfg_data;
                REG_RESET_LOW:    cfg_next.reset_low_us          = cfg_data;
                REG_PRESENCE_IVL: cfg_next.presence_interval_us  = cfg_data[7:0];
                REG_WRITE_SLOT:   cfg_next.write_slot_us         = cfg_data[7:0];
                REG_WRITE_START:  cfg_next.write_start_us        = cfg_data[7:0];
                REG_READ_START:   cfg_next.read_start_us         = cfg_data[7:0];
                REG_READ_SAMPLE:  cfg_next.read_sample_offset_us = cfg_data[7:0];
                REG_READ_SLOT:    cfg_next.read_slot_us          = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    owbm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick_data  (tick_data),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop)
    );

    owbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

>>> rtl/core/owbm_front.sv
module owbm_front
    import owbm_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tick_valid,
    output logic  tick_ready,
    input  tick_t tick_data,
    output logic  job_valid,
    output job_t  job,
    input  logic  job_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [4:0] MAX_COUNT = 5'(MAX_BITS);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    job_t             job_in;
    logic             push;
    logic             pop;

    assign tick_ready = (cnt_reg != FULL_CNT);
    assign job_valid  = (cnt_reg != '0);
    assign job        = mem_reg[rd_ptr_reg];
    assign push       = tick_valid && tick_ready;
    assign pop        = job_pop && job_valid;

    // Classify: decode the command and clamp the bit count
    always_comb
    begin
        job_in.cmd   = cmd_t'(tick_data.command);
        job_in.count = (tick_data.bit_count > MAX_COUNT) ? MAX_COUNT : tick_data.bit_count;
        job_in.wdata = tick_data.write_data;
        job_in.line  = tick_data.line_in;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

>>> rtl/core/owbm_back.sv
module owbm_back
    import owbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_data
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_REC_W    = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_HIGH   = 4'd5,
        PH_REC_R    = 4'd6,
        PH_R_LOW    = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_TAIL   = 4'd9,
        PH_FIN_W    = 4'd10,
        PH_FIN_R    = 4'd11,
        PH_FIN_RST  = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_HEAD = 2'd0,
        ST_PRE  = 2'd1,
        ST_BODY = 2'd2,
        ST_POST = 2'd3
    } st_t;

    typedef struct packed {
        phase_t      phase;
        phase_t      tgt;
        logic [9:0]  timer;
        logic [7:0]  itimer;
        logic [4:0]  bits_left;
        logic [3:0]  bit_pos;
        logic [15:0] shift;
        logic [15:0] read_res;
        logic [9:0]  low_cnt;
        logic        fin;
        logic        drv;
        logic        settled;
    } eng_t;

    localparam eng_t ENG_RESET = '{
        phase:     PH_IDLE,
        tgt:       PH_IDLE,
        timer:     10'd0,
        itimer:    8'd0,
        bits_left: 5'd0,
        bit_pos:   4'd0,
        shift:     16'd0,
        read_res:  16'd0,
        low_cnt:   10'd0,
        fin:       1'b0,
        drv:       1'b0,
        settled:   1'b0
    };

    function automatic eng_t end_bit(eng_t w, logic reading);
        if (!reading)
        begin
            w.shift = {1'b0, w.shift[15:1]};
        end
        w.bit_pos = w.bit_pos + 4'd1;
        if (w.bits_left != 5'd0)
        begin
            w.bits_left = w.bits_left - 5'd1;
        end
        if (w.bits_left == 5'd0)
        begin
            w.tgt = reading ? PH_FIN_R : PH_FIN_W;
        end
        else
        begin
            w.tgt = reading ? PH_REC_R : PH_REC_W;
        end
        return w;
    endfunction

    // Enter the target phase; a zero-length phase leaves the next target in tgt
    function automatic eng_t go_step(eng_t w, cfg_t c, logic [7:0] ci);
        phase_t     cur;
        logic [9:0] len;
        logic [8:0] sum;
        logic [8:0] tail;
        logic       one;
        logic       stop;
        cur  = w.tgt;
        len  = 10'd0;
        one  = w.shift[0];
        stop = 1'b0;
        sum  = {1'b0, c.read_sample_offset_us} + {1'b0, c.read_start_us};
        tail = {1'b0, c.read_slot_us} - sum;
        unique case (cur) inside
            PH_RST_LOW:
            begin
                len   = c.reset_low_us;
                w.tgt = PH_RST_WAIT;
            end
            PH_RST_WAIT:
            begin
                // Timer holds the ticks left in the window; zero if no full interval fits
                w.itimer = ci;
                if (c.reset_low_us >= {2'b00, ci})
                begin
                    len = c.reset_low_us;
                end
                w.tgt = PH_FIN_RST;
            end
            PH_REC_W:
            begin
                len   = c.recovery_us;
                w.tgt = PH_W_LOW;
            end
            PH_W_LOW:
            begin
                len   = {2'b00, one ? c.write_start_us : c.write_slot_us};
                w.tgt = PH_W_HIGH;
            end
            PH_W_HIGH:
            begin
                if (one && (c.write_slot_us > c.write_start_us))
                begin
                    len = {2'b00, c.write_slot_us - c.write_start_us};
                end
                else
                begin
                    w = end_bit(w, 1'b0);
                end
            end
            PH_REC_R:
            begin
                len   = c.recovery_us;
                w.tgt = PH_R_LOW;
            end
            PH_R_LOW:
            begin
                len   = {2'b00, c.read_start_us};
                w.tgt = PH_R_WAIT;
            end
            PH_R_WAIT:
            begin
                len = (c.read_sample_offset_us > c.read_start_us)
                    ? {2'b00, c.read_sample_offset_us - c.read_start_us} : 10'd1;
                w.tgt = PH_R_TAIL;
            end
            PH_R_TAIL:
            begin
                if ({1'b0, c.read_slot_us} > sum)
                begin
                    len = {1'b0, tail};
                end
                else
                begin
                    w = end_bit(w, 1'b1);
                end
            end
            PH_FIN_R:
            begin
                w.read_res = w.shift;
                w.fin      = 1'b1;
                stop       = 1'b1;
            end
            PH_FIN_W, PH_FIN_RST:
            begin
                w.fin = 1'b1;
                stop  = 1'b1;
            end
            default:
            begin
                stop = 1'b1;
            end
        endcase
        if (stop)
        begin
            w.phase = PH_IDLE;
        end
        else if (len != 10'd0)
        begin
            w.phase = cur;
            w.timer = len;
            stop    = 1'b1;
        end
        w.settled = stop;
        return w;
    endfunction

    st_t        st_reg;
    st_t        st_next;
    eng_t       eng_reg;
    eng_t       eng_next;
    logic       res_valid_reg;
    res_t       res_data_reg;
    logic [7:0] ci;
    logic       go_en;
    logic       body_en;
    logic       pre_go;
    logic       expired;
    logic       emit;
    logic       stall;
    logic       res_free;
    logic [9:0] timer_dec;
    logic [7:0] itimer_dec;

    assign ci       = (cfg.presence_interval_us == 8'd0) ? 8'd1 : cfg.presence_interval_us;
    assign res_free = !res_valid_reg || res_ready;
    assign stall    = emit && !res_free;
    assign job_pop  = emit && !stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        eng_next   = eng_reg;
        st_next    = st_reg;
        go_en      = 1'b0;
        body_en    = 1'b0;
        pre_go     = 1'b0;
        expired    = 1'b0;
        emit       = 1'b0;
        timer_dec  = eng_reg.timer - 10'd1;
        itimer_dec = eng_reg.itimer - 8'd1;

        unique case (st_reg)
            ST_HEAD:
            begin
                if (job_valid)
                begin
                    eng_next.fin = 1'b0;
                    eng_next.drv = 1'b0;
                    if (eng_reg.phase == PH_IDLE)
                    begin
                        if (job.cmd != CMD_TICK)
                        begin
                            eng_next.bit_pos = 4'd0;
                            unique case (job.cmd)
                                CMD_RESET:
                                begin
                                    eng_next.low_cnt = 10'd0;
                                    eng_next.tgt     = PH_RST_LOW;
                                end
                                CMD_WRITE:
                                begin
                                    eng_next.shift     = job.wdata;
                                    eng_next.bits_left = job.count;
                                    eng_next.tgt = (job.count != 5'd0) ? PH_REC_W : PH_FIN_W;
                                end
                                CMD_READ:
                                begin
                                    eng_next.shift     = 16'd0;
                                    eng_next.bits_left = job.count;
                                    eng_next.tgt = (job.count != 5'd0) ? PH_REC_R : PH_FIN_R;
                                end
                                default:
                                begin
                                    eng_next.tgt = PH_IDLE;
                                end
                            endcase
                            go_en  = 1'b1;
                            pre_go = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    else
                    begin
                        body_en = 1'b1;
                    end
                end
            end
            ST_PRE:
            begin
                go_en  = 1'b1;
                pre_go = 1'b1;
            end
            ST_BODY:
            begin
                body_en = 1'b1;
            end
            ST_POST:
            begin
                go_en = 1'b1;
            end
            default:
            begin
                st_next = ST_HEAD;
            end
        endcase

        // One tick of the settled phase
        if (body_en)
        begin
            eng_next.drv   = eng_reg.phase inside {PH_RST_LOW, PH_W_LOW, PH_R_LOW};
            eng_next.timer = timer_dec;
            if (eng_reg.phase == PH_RST_WAIT)
            begin
                if (itimer_dec == 8'd0)
                begin
                    if (!job.line && (eng_reg.low_cnt != 10'h3FF))
                    begin
                        eng_next.low_cnt = eng_reg.low_cnt + 10'd1;
                    end
                    eng_next.itimer = ci;
                    expired = (timer_dec < {2'b00, ci});
                end
                else
                begin
                    eng_next.itimer = itimer_dec;
                end
            end
            else
            begin
                expired = (timer_dec == 10'd0);
            end

            if (expired)
            begin
                unique case (eng_reg.phase) inside
                    PH_RST_LOW:  eng_next.tgt = PH_RST_WAIT;
                    PH_RST_WAIT: eng_next.tgt = PH_FIN_RST;
                    PH_REC_W:    eng_next.tgt = PH_W_LOW;
                    PH_W_LOW:    eng_next.tgt = PH_W_HIGH;
                    PH_W_HIGH:   eng_next = end_bit(eng_next, 1'b0);
                    PH_REC_R:    eng_next.tgt = PH_R_LOW;
                    PH_R_LOW:    eng_next.tgt = PH_R_WAIT;
                    PH_R_WAIT:
                    begin
                        if (job.line)
                        begin
                            eng_next.shift[eng_reg.bit_pos] = 1'b1;
                        end
                        eng_next.tgt = PH_R_TAIL;
                    end
                    PH_R_TAIL:   eng_next = end_bit(eng_next, 1'b1);
                    default:     eng_next.tgt = PH_IDLE;
                endcase
                go_en = 1'b1;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        // Walk one phase; a zero-length phase continues the walk from ST_PRE or ST_POST
        if (go_en)
        begin
            eng_next = go_step(eng_next, cfg, ci);
            if (eng_next.settled)
            begin
                if (pre_go && (eng_next.phase != PH_IDLE))
                begin
                    st_next = ST_BODY;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            else
            begin
                st_next = pre_go ? ST_PRE : ST_POST;
            end
        end

        if (emit)
        begin
            st_next = ST_HEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_HEAD;
            eng_reg       <= ENG_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                st_reg  <= st_next;
                eng_reg <= eng_next;
            end
            if (emit && !stall)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && !stall)
        begin
            res_data_reg.drive_low      <= eng_next.drv;
            res_data_reg.busy_res       <= (eng_next.phase != PH_IDLE);
            res_data_reg.done_res       <= eng_next.fin;
            res_data_reg.read_data      <= eng_next.read_res;
            res_data_reg.presence_count <= eng_next.low_cnt;
        end
    end

`ifndef SYNTH
    // The item stays at the queue head until its result is produced
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_HEAD) |-> job_valid)
        else $error("item left the queue while still in progress");

    a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((eng_reg.phase != PH_IDLE) && (st_reg != ST_POST)) |-> (eng_reg.timer != 10'd0))
        else $error("active phase with expired timer");

    a_interval_live: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg.phase == PH_RST_WAIT) |-> (eng_reg.itimer != 8'd0))
        else $error("presence interval timer at zero");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.done_res) |-> !res_data_reg.busy_res)
        else $error("finished command still reported busy");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        eng_reg.bits_left <= 5'(MAX_BITS))
        else $error("bit counter beyond transfer limit");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import owbm_pkg::*;

    typedef enum int {
        BUS_IDLE,
        RST_PULSE,
        RST_LISTEN,
        WR_GAP,
        WR_LOW,
        WR_REL,
        RD_GAP,
        RD_LOW,
        RD_WAIT,
        RD_TAIL,
        FIN_WR,
        FIN_RD,
        FIN_RST
    } bus_phase_e;

    typedef enum int { LINE_LOW, LINE_HIGH, LINE_NOISE } line_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       tick_valid = 1'b0;
    logic       tick_ready;
    tick_t      tick_data = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    res_t       res_data;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    // Bus model state, advanced once per item sent
    cfg_t        timing;
    bus_phase_e  bus_phase = BUS_IDLE;
    int unsigned phase_ticks = 0;
    int unsigned sample_ticks = 0;
    int unsigned bits_todo = 0;
    int unsigned bit_idx = 0;
    int unsigned low_count = 0;
    logic [15:0] shreg = '0;
    logic [15:0] rd_word = '0;
    bit          cmd_done = 1'b0;

    res_t bus_status_q[$];

    bit idling_on = 1'b1;
    int error_count = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int resets_run = 0;
    int writes_run = 0;
    int reads_run = 0;
    int ignored_cmds = 0;
    int settings_used = 0;

    one_wire_bus_master u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick_data  (tick_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned sample_period();
        return (timing.presence_interval_us != 0) ? timing.presence_interval_us : 1;
    endfunction

    function automatic bus_phase_e close_bit(bit reading);
        if (!reading)
            shreg = shreg >> 1;
        bit_idx++;
        if (bits_todo != 0)
            bits_todo--;
        if (bits_todo == 0)
            return reading ? FIN_RD : FIN_WR;
        return reading ? RD_GAP : WR_GAP;
    endfunction

    // Walk into phase p, skipping phases of zero length and closing the command
    function automatic void enter_phase(bus_phase_e p);
        int unsigned len;
        int unsigned ws;
        int unsigned wst;
        int unsigned rs;
        int unsigned off;
        int unsigned slot;
        bus_phase_e  nxt;
        ws   = timing.write_slot_us;
        wst  = timing.write_start_us;
        rs   = timing.read_start_us;
        off  = timing.read_sample_offset_us;
        slot = timing.read_slot_us;
        while (1)
        begin
            len = 0;
            nxt = BUS_IDLE;
            case (p)
                RST_PULSE:
                begin
                    len = timing.reset_low_us;
                    nxt = RST_LISTEN;
                end
                RST_LISTEN:
                begin
                    len = (timing.reset_low_us / sample_period()) * sample_period();
                    sample_ticks = sample_period();
                    nxt = FIN_RST;
                end
                WR_GAP:
                begin
                    len = timing.recovery_us;
                    nxt = WR_LOW;
                end
                WR_LOW:
                begin
                    len = shreg[0] ? wst : ws;
                    nxt = WR_REL;
                end
                WR_REL:
                begin
                    len = (shreg[0] && ws > wst) ? ws - wst : 0;
                    if (len == 0)
                        nxt = close_bit(1'b0);
                end
                RD_GAP:
                begin
                    len = timing.recovery_us;
                    nxt = RD_LOW;
                end
                RD_LOW:
                begin
                    len = rs;
                    nxt = RD_WAIT;
                end
                RD_WAIT:
                    len = (off > rs) ? off - rs : 1;
                RD_TAIL:
                begin
                    len = (slot > off + rs) ? slot - off - rs : 0;
                    if (len == 0)
                        nxt = close_bit(1'b1);
                end
                FIN_RD:
                begin
                    rd_word = shreg;
                    cmd_done = 1'b1;
                    bus_phase = BUS_IDLE;
                    return;
                end
                FIN_WR, FIN_RST:
                begin
                    cmd_done = 1'b1;
                    bus_phase = BUS_IDLE;
                    return;
                end
                default:
                begin
                    bus_phase = BUS_IDLE;
                    return;
                end
            endcase
            if (len != 0)
            begin
                bus_phase = p;
                phase_ticks = len;
                return;
            end
            p = nxt;
        end
    endfunction

    // One microsecond tick of the bus master; returns the status it reports
    function automatic res_t advance_bus(tick_t t);
        res_t        r;
        cmd_t        c;
        int unsigned cnt;
        bit          drive;
        c = cmd_t'(t.command);
        cmd_done = 1'b0;
        drive = 1'b0;
        if (bus_phase == BUS_IDLE && c != CMD_TICK)
        begin
            cnt = (t.bit_count > MAX_BITS) ? MAX_BITS : t.bit_count;
            bit_idx = 0;
            case (c)
                CMD_RESET:
                begin
                    low_count = 0;
                    resets_run++;
                    enter_phase(RST_PULSE);
                end
                CMD_WRITE:
                begin
                    shreg = t.write_data;
                    bits_todo = cnt;
                    writes_run++;
                    enter_phase((cnt != 0) ? WR_GAP : FIN_WR);
                end
                default:
                begin
                    shreg = '0;
                    bits_todo = cnt;
                    reads_run++;
                    enter_phase((cnt != 0) ? RD_GAP : FIN_RD);
                end
            endcase
        end
        else if (c != CMD_TICK)
            ignored_cmds++;

        if (bus_phase != BUS_IDLE)
        begin
            drive = (bus_phase == RST_PULSE || bus_phase == WR_LOW || bus_phase == RD_LOW);
            if (bus_phase == RST_LISTEN)
            begin
                if (sample_ticks != 0)
                    sample_ticks--;
                if (sample_ticks == 0)
                begin
                    if (!t.line_in && low_count < 1023)
                        low_count++;
                    sample_ticks = sample_period();
                end
            end
            if (phase_ticks != 0)
                phase_ticks--;
            if (phase_ticks == 0)
            begin
                case (bus_phase)
                    RST_PULSE:  enter_phase(RST_LISTEN);
                    RST_LISTEN: enter_phase(FIN_RST);
                    WR_GAP:     enter_phase(WR_LOW);
                    WR_LOW:     enter_phase(WR_REL);
                    WR_REL:     enter_phase(close_bit(1'b0));
                    RD_GAP:     enter_phase(RD_LOW);
                    RD_LOW:     enter_phase(RD_WAIT);
                    RD_WAIT:
                    begin
                        if (t.line_in && bit_idx < 16)
                            shreg[bit_idx] = 1'b1;
                        enter_phase(RD_TAIL);
                    end
                    RD_TAIL:    enter_phase(close_bit(1'b1));
                    default:    bus_phase = BUS_IDLE;
                endcase
            end
        end

        r.drive_low      = drive;
        r.busy_res       = (bus_phase != BUS_IDLE);
        r.done_res       = cmd_done;
        r.read_data      = rd_word;
        r.presence_count = low_count[9:0];
        return r;
    endfunction

    function automatic tick_t make_tick(cmd_t c, int count, logic [15:0] data, logic line);
        tick_t t;
        t.command    = c;
        t.bit_count  = 5'(count);
        t.write_data = data;
        t.line_in    = line;
        return t;
    endfunction

    function automatic logic pick_line(line_e mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic cfg_t timing_of(int rec, int rlow, int intv, int wslot, int wstart,
                                       int rstart, int roff, int rslot);
        cfg_t c;
        c.recovery_us           = 10'(rec);
        c.reset_low_us          = 10'(rlow);
        c.presence_interval_us  = 8'(intv);
        c.write_slot_us         = 8'(wslot);
        c.write_start_us        = 8'(wstart);
        c.read_start_us         = 8'(rstart);
        c.read_sample_offset_us = 8'(roff);
        c.read_slot_us          = 8'(rslot);
        return c;
    endfunction

    function automatic cfg_t random_timing();
        return timing_of($urandom_range(0, 6), $urandom_range(1, 30), $urandom_range(1, 6),
                         $urandom_range(2, 10), $urandom_range(1, 10), $urandom_range(1, 6),
                         $urandom_range(1, 10), $urandom_range(2, 20));
    endfunction

    task automatic send_tick(input tick_t item);
        int gap;
        gap = (idling_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= item;
        bus_status_q.push_back(advance_bus(item));
        ticks_sent++;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted status has come back
    task automatic drain_results();
        @(negedge clk);
        tick_valid <= 1'b0;
        while (bus_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [9:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_timing(input cfg_t c);
        drain_results();
        write_reg(REG_RECOVERY, c.recovery_us);
        write_reg(REG_RESET_LOW, c.reset_low_us);
        write_reg(REG_PRESENCE_IVL, {2'b00, c.presence_interval_us});
        write_reg(REG_WRITE_SLOT, {2'b00, c.write_slot_us});
        write_reg(REG_WRITE_START, {2'b00, c.write_start_us});
        write_reg(REG_READ_START, {2'b00, c.read_start_us});
        write_reg(REG_READ_SAMPLE, {2'b00, c.read_sample_offset_us});
        write_reg(REG_READ_SLOT, {2'b00, c.read_slot_us});
        @(negedge clk);
        cfg_write <= 1'b0;
        timing = c;
        settings_used++;
    endtask

    // Tick the bus until the running command completes; stray commands are mixed in
    task automatic finish_command(input line_e mode);
        tick_t item;
        while (bus_phase != BUS_IDLE)
        begin
            item = make_tick(CMD_TICK, $urandom_range(0, 31), 16'($urandom), pick_line(mode));
            if ($urandom_range(0, 5) == 0)
                item.command = cmd_t'($urandom_range(1, 3));
            send_tick(item);
        end
    endtask

    task automatic run_command(input cmd_t c, input int count, input logic [15:0] data,
                               input line_e mode);
        send_tick(make_tick(c, count, data, pick_line(mode)));
        finish_command(mode);
    endtask

    task automatic random_command();
        int pick;
        int count;
        pick = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0:       count = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
            1, 2, 3,
            4:       count = $urandom_range(1, 4);
            default: count = $urandom_range(5, 16);
        endcase
        if (pick == 0)
            send_tick(make_tick(CMD_TICK, count, 16'($urandom), 1'($urandom_range(0, 1))));
        else
            run_command(cmd_t'(pick % 3 + 1), count, 16'($urandom), LINE_NOISE);
    endtask

    task automatic test_defaults();
        run_command(CMD_WRITE, 1, 16'h0001, LINE_HIGH);
        run_command(CMD_READ, 1, 16'h0000, LINE_NOISE);
    endtask

    task automatic test_bit_counts();
        set_timing(timing_of(1, 12, 3, 6, 2, 1, 3, 6));
        run_command(CMD_WRITE, 0, 16'hFFFF, LINE_NOISE);
        run_command(CMD_READ, 0, 16'h0000, LINE_HIGH);
        run_command(CMD_WRITE, 16, 16'hFFFF, LINE_NOISE);
        run_command(CMD_READ, 17, 16'h0000, LINE_HIGH);
        run_command(CMD_WRITE, 31, 16'h5A3C, LINE_NOISE);
        run_command(CMD_RESET, 31, 16'hFFFF, LINE_HIGH);
        send_tick(make_tick(CMD_TICK, 31, 16'hFFFF, 1'b1));
    endtask

    task automatic test_zero_phases();
        // zero interval, a one that is never released, sample before the low ends, no tail
        set_timing(timing_of(0, 5, 0, 1, 5, 3, 2, 2));
        run_command(CMD_RESET, 1, 16'h0000, LINE_LOW);
        run_command(CMD_WRITE, 4, 16'h0005, LINE_NOISE);
        run_command(CMD_READ, 5, 16'h0000, LINE_NOISE);
        // every slot length zero, window shorter than one interval
        set_timing(timing_of(0, 10, 255, 0, 0, 0, 0, 0));
        run_command(CMD_WRITE, 16, 16'h0000, LINE_NOISE);
        run_command(CMD_WRITE, 16, 16'hFFFF, LINE_NOISE);
        run_command(CMD_READ, 16, 16'h0000, LINE_HIGH);
        run_command(CMD_RESET, 2, 16'h0000, LINE_LOW);
    endtask

    task automatic test_full_scale();
        cfg_t c;
        c = timing_of(2, 20, 255, 255, 255, 255, 255, 255);
        set_timing(c);
        run_command(CMD_RESET, 0, 16'h0000, LINE_LOW);
        run_command(CMD_READ, 1, 16'h0000, LINE_HIGH);
        // one sample per tick across the window
        c.presence_interval_us = 8'd1;
        set_timing(c);
        run_command(CMD_RESET, 0, 16'h0000, LINE_LOW);
    endtask

    task automatic test_sender_pause();
        set_timing(timing_of(3, 8, 2, 8, 3, 2, 4, 9));
        send_tick(make_tick(CMD_READ, 8, 16'h0000, 1'b1));
        repeat (5) send_tick(make_tick(CMD_TICK, 0, 16'h0000, 1'($urandom_range(0, 1))));
        drain_results();
        finish_command(LINE_NOISE);
    endtask

    task automatic test_random();
        int target;
        for (int s = 0; s < 4; s++)
        begin
            set_timing(random_timing());
            target = ticks_sent + 70;
            while (ticks_sent < target)
                random_command();
        end
    endtask

    task automatic test_no_idling();
        int target;
        idling_on = 1'b0;
        set_timing(random_timing());
        target = ticks_sent + 110;
        while (ticks_sent < target)
            random_command();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (bus_status_q.size() == 0)
            begin
                $error("unexpected result item %h", res_data);
                error_count++;
            end
            else
            begin
                want = bus_status_q.pop_front();
                check_field("drive_low", 16'(want.drive_low), 16'(res_data.drive_low));
                check_field("busy_res", 16'(want.busy_res), 16'(res_data.busy_res));
                check_field("done_res", 16'(want.done_res), 16'(res_data.done_res));
                check_field("read_data", want.read_data, res_data.read_data);
                check_field("presence_count", 16'(want.presence_count),
                            16'(res_data.presence_count));
                results_seen++;
            end
        end
    end

    // Receiver stalls in random bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            res_ready <= 1'b1;
        end
    end

    initial
    begin
        #5000000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        timing = timing_of(200, 480, 15, 60, 1, 1, 10, 15);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_bit_counts();
        test_zero_phases();
        test_full_scale();
        test_sender_pause();
        test_random();
        test_no_idling();

        drain_results();
        repeat (20) @(posedge clk);
        $display("summary: %0d ticks checked over %0d timing settings", results_seen,
                 settings_used);
        $display("summary: %0d resets, %0d writes, %0d reads; %0d commands dropped while busy",
                 resets_run, writes_run, reads_run, ignored_cmds);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
